// File: rtl/stl_pkg.sv
// Package for the source token lexer: result item, scan state and kind tables.
// Used by stl_step, stl_outq and source_token_lexer_core.
package stl_pkg;

  localparam logic [5:0] KindNegate = 6'd0;
  localparam logic [5:0] KindId     = 6'd1;
  localparam logic [5:0] KindInt    = 6'd2;
  localparam logic [5:0] KindHex    = 6'd3;
  localparam logic [5:0] KindBin    = 6'd4;
  localparam logic [5:0] KindString = 6'd5;
  localparam logic [5:0] KindChar   = 6'd6;
  localparam logic [5:0] KindDot    = 6'd44;
  localparam logic [5:0] KindEnd    = 6'd47;
  localparam logic [5:0] KindError  = 6'd48;

  localparam logic [2:0] KwMiss = 3'd4;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_ZERO, MODE_DEC, MODE_HEX, MODE_BIN,
    MODE_STR, MODE_CHR, MODE_OPER, MODE_DOTS, MODE_LINE, MODE_BLOCK
  } mode_e;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] vbyte;
    logic       present;
    logic       last;
  } item_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] hb;
    logic       hv;
    logic [2:0] kp;
    logic [1:0] dr;
    logic       el;
  } state_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_opstart(logic [7:0] c);
    return c == "-" || c == "+" || c == "=" || c == "&" || c == "<" ||
           c == "|" || c == ">" || c == "*";
  endfunction

  // {hit, kind}
  function automatic logic [6:0] single_kind(logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    unique case (c)
      ",": r = {1'b1, 6'd31};
      ";": r = {1'b1, 6'd32};
      ":": r = {1'b1, 6'd33};
      "^": r = {1'b1, 6'd34};
      "%": r = {1'b1, 6'd35};
      "!": r = {1'b1, KindNegate};
      "#": r = {1'b1, 6'd36};
      "?": r = {1'b1, 6'd37};
      "(": r = {1'b1, 6'd38};
      "[": r = {1'b1, 6'd39};
      "{": r = {1'b1, 6'd40};
      ")": r = {1'b1, 6'd41};
      "]": r = {1'b1, 6'd42};
      "}": r = {1'b1, 6'd43};
      "/": r = {1'b1, 6'd45};
      "@": r = {1'b1, 6'd46};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    unique case (a)
      "-": r = (b == ">") ? {1'b1, 6'd7} : (b == "-") ? {1'b1, 6'd8} :
               (b == "?") ? {1'b1, 6'd9} : 7'd0;
      "+": r = (b == "+") ? {1'b1, 6'd11} : 7'd0;
      "=": r = (b == ">") ? {1'b1, 6'd13} : (b == "=") ? {1'b1, 6'd14} :
               (b == "?") ? {1'b1, 6'd15} : 7'd0;
      "&": r = (b == "&") ? {1'b1, 6'd17} : (b == "?") ? {1'b1, 6'd18} : 7'd0;
      "<": r = (b == "=") ? {1'b1, 6'd20} : (b == "-") ? {1'b1, 6'd21} :
               (b == "<") ? {1'b1, 6'd22} : 7'd0;
      "|": r = (b == "|") ? {1'b1, 6'd24} : 7'd0;
      ">": r = (b == "=") ? {1'b1, 6'd26} : (b == ">") ? {1'b1, 6'd27} : 7'd0;
      "*": r = (b == "*") ? {1'b1, 6'd29} : 7'd0;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] lone_kind(logic [7:0] a);
    logic [5:0] r;
    unique case (a)
      "-": r = 6'd10;
      "+": r = 6'd12;
      "=": r = 6'd16;
      "&": r = 6'd19;
      "<": r = 6'd23;
      "|": r = 6'd25;
      ">": r = 6'd28;
      default: r = 6'd30;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/stl_step.sv
// Next-state and result logic for one source byte; holds the scan state.
// Depends on stl_pkg.
module stl_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     c_i,
  output logic [1:0]     n_o,
  output stl_pkg::item_t it0_o,
  output stl_pkg::item_t it1_o,
  output logic           lock_o
);
  import stl_pkg::*;

  typedef struct packed {
    state_t     st;
    item_t      i0;
    item_t      i1;
    logic [1:0] n;
  } ctx_t;

  state_t st_q, st_d;
  ctx_t   cx;

  function automatic ctx_t emit(ctx_t x, logic [5:0] k, logic [7:0] b, logic p, logic l);
    item_t it;
    it.kind    = k;
    it.vbyte   = p ? b : 8'd0;
    it.present = p;
    it.last    = l;
    if (x.n == 2'd0) x.i0 = it;
    else x.i1 = it;
    x.n = x.n + 2'd1;
    return x;
  endfunction

  function automatic ctx_t shift_in(ctx_t x, logic [7:0] c);
    if (x.st.hv) x = emit(x, KindNegate, x.st.hb, 1'b1, 1'b0);
    x.st.hb = c;
    x.st.hv = 1'b1;
    return x;
  endfunction

  function automatic ctx_t finish(ctx_t x, logic [5:0] k);
    x = emit(x, k, x.st.hb, x.st.hv, 1'b1);
    x.st.hv   = 1'b0;
    x.st.hb   = 8'd0;
    x.st.kp   = 3'd0;
    x.st.dr   = 2'd0;
    x.st.mode = MODE_IDLE;
    return x;
  endfunction

  function automatic ctx_t start_token(ctx_t x, logic [7:0] c);
    logic [6:0] sk;
    sk = single_kind(c);
    x.st.hv = 1'b0;
    x.st.hb = 8'd0;
    priority if (c == 8'd0) begin
      x = finish(x, KindEnd);
    end else if (c == 8'd13 || c == 8'd10 || c == " " || c == 8'd9) begin
    end else if (is_alpha(c)) begin
      x.st.mode = MODE_IDENT;
      x.st.kp   = (c == "n") ? 3'd1 : KwMiss;
      x = shift_in(x, c);
    end else if (is_digit(c)) begin
      x.st.mode = (c == "0") ? MODE_ZERO : MODE_DEC;
      x = shift_in(x, c);
    end else if (c == "\"") begin
      x.st.mode = MODE_STR;
    end else if (c == "'") begin
      x.st.mode = MODE_CHR;
    end else if (c == ".") begin
      x.st.mode = MODE_DOTS;
      x.st.dr   = 2'd1;
    end else if (is_opstart(c)) begin
      x.st.mode = MODE_OPER;
      x = shift_in(x, c);
    end else if (sk[6]) begin
      x = emit(x, sk[5:0], c, 1'b1, 1'b1);
    end else begin
      x = emit(x, KindError, c, 1'b1, 1'b1);
      x.st.el = 1'b1;
    end
    return x;
  endfunction

  always_comb begin
    logic [6:0] pk;
    logic [7:0] c;
    c  = c_i;
    cx = '0;
    cx.st = st_q;
    pk = pair_kind(st_q.hb, c);
    if (st_q.el) begin
      if (c == 8'd0) begin
        cx.st.el = 1'b0;
        cx = finish(cx, KindEnd);
      end
    end else begin
      unique case (st_q.mode)
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (st_q.kp == 3'd1 && c == "o") cx.st.kp = 3'd2;
            else if (st_q.kp == 3'd2 && c == "t") cx.st.kp = 3'd3;
            else cx.st.kp = KwMiss;
            cx = shift_in(cx, c);
          end else begin
            cx = finish(cx, (st_q.kp == 3'd3) ? KindNegate : KindId);
            cx = start_token(cx, c);
          end
        end
        MODE_ZERO: begin
          if (c == "x" || c == "b") begin
            cx.st.mode = (c == "x") ? MODE_HEX : MODE_BIN;
            cx.st.hv = 1'b0;
            cx.st.hb = 8'd0;
          end else if (is_digit(c)) begin
            cx.st.mode = MODE_DEC;
            cx = shift_in(cx, c);
          end else begin
            cx = finish(cx, KindInt);
            cx = start_token(cx, c);
          end
        end
        MODE_DEC: begin
          if (is_digit(c)) cx = shift_in(cx, c);
          else begin
            cx = finish(cx, KindInt);
            cx = start_token(cx, c);
          end
        end
        MODE_HEX: begin
          if (is_xdigit(c)) cx = shift_in(cx, c);
          else begin
            cx = finish(cx, KindHex);
            cx = start_token(cx, c);
          end
        end
        MODE_BIN: begin
          if (c == "0" || c == "1") cx = shift_in(cx, c);
          else begin
            cx = finish(cx, KindBin);
            cx = start_token(cx, c);
          end
        end
        MODE_STR, MODE_CHR: begin
          if (c == ((st_q.mode == MODE_STR) ? 8'h22 : 8'h27)) begin
            cx = finish(cx, (st_q.mode == MODE_STR) ? KindString : KindChar);
          end else if (c == 8'd0) begin
            cx = finish(cx, (st_q.mode == MODE_STR) ? KindString : KindChar);
            cx = start_token(cx, c);
          end else begin
            cx = shift_in(cx, c);
          end
        end
        MODE_OPER: begin
          if (pk[6]) begin
            cx = shift_in(cx, c);
            cx = finish(cx, pk[5:0]);
          end else begin
            cx = finish(cx, lone_kind(st_q.hb));
            cx = start_token(cx, c);
          end
        end
        MODE_DOTS: begin
          if (st_q.dr < 2'd2) begin
            if (c == ".") cx.st.dr = 2'd2;
            else begin
              cx.st.hb = ".";
              cx.st.hv = 1'b1;
              cx = finish(cx, KindDot);
              cx = start_token(cx, c);
            end
          end else if (c == ".") begin
            cx.st.mode = MODE_BLOCK;
            cx.st.dr   = 2'd2;
          end else if (c == 8'd10) begin
            cx.st.mode = MODE_IDLE;
            cx.st.dr   = 2'd0;
          end else if (c == 8'd0) begin
            cx = start_token(cx, c);
          end else begin
            cx.st.mode = MODE_LINE;
            cx.st.dr   = 2'd0;
          end
        end
        MODE_LINE: begin
          if (c == 8'd10) cx.st.mode = MODE_IDLE;
          else if (c == 8'd0) cx = start_token(cx, c);
        end
        MODE_BLOCK: begin
          if (c == 8'd0) cx = start_token(cx, c);
          else if (c == ".") begin
            if (st_q.dr >= 2'd2) begin
              cx.st.dr   = 2'd0;
              cx.st.mode = MODE_IDLE;
            end else begin
              cx.st.dr = st_q.dr + 2'd1;
            end
          end else begin
            cx.st.dr = 2'd0;
          end
        end
        default: begin
          cx.st.mode = MODE_IDLE;
          cx = start_token(cx, c);
        end
      endcase
    end
    st_d = step_i ? cx.st : st_q;
  end

  assign n_o    = cx.n;
  assign it0_o  = cx.i0;
  assign it1_o  = cx.i1;
  assign lock_o = st_q.el;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: MODE_IDLE, default: '0};
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: rtl/stl_outq.sv
// Four-entry result queue, up to two writes per cycle, one read.
// Depends on stl_pkg.
module stl_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     wr_n_i,
  input  stl_pkg::item_t wr0_i,
  input  stl_pkg::item_t wr1_i,
  input  logic           rd_i,
  output stl_pkg::item_t rd_o,
  output logic [2:0]     cnt_o
);
  import stl_pkg::*;

  item_t      mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       rd;

  assign rd    = rd_i && (cnt_q != 3'd0);
  assign rd_o  = mem_q[rp_q];
  assign cnt_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) mem_q[wp_q] <= wr0_i;
    if (wr_n_i == 2'd2) mem_q[wp_q + 2'd1] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + wr_n_i;
      rp_q  <= rp_q + {1'b0, rd};
      cnt_q <= cnt_q + {1'b0, wr_n_i} - {2'b0, rd};
    end
  end

endmodule

// File: rtl/source_token_lexer_core.sv
// Source token lexer: one byte a cycle in, token bytes out with kind on last.
// A result is written into the registered result queue at the edge that accepts the byte that causes it.
// Throughput: one byte per cycle while the result queue has two free slots.
// Reset (asynchronous, active low) idles the scanner and empties the queue.
// Depends on stl_pkg, stl_step, stl_outq.
module source_token_lexer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] token_kind_o,
  output logic [7:0] value_byte_o,
  output logic       value_present_o,
  output logic       last_of_token_o
);
  import stl_pkg::*;

  logic       acc;
  logic [1:0] n, wr_n;
  item_t      it0, it1, head;
  logic [2:0] cnt;
  logic       lock;

  assign in_ready_o = cnt <= 3'd2;
  assign acc        = in_valid_i && in_ready_o;
  assign wr_n       = acc ? n : 2'd0;

  stl_step u_step (
    .clk_i, .rst_ni, .step_i(acc), .c_i(char_byte_i),
    .n_o(n), .it0_o(it0), .it1_o(it1), .lock_o(lock)
  );

  stl_outq u_q (
    .clk_i, .rst_ni, .wr_n_i(wr_n), .wr0_i(it0), .wr1_i(it1),
    .rd_i(out_ready_i), .rd_o(head), .cnt_o(cnt)
  );

  assign out_valid_o     = cnt != 3'd0;
  assign token_kind_o    = head.kind;
  assign value_byte_o    = head.vbyte;
  assign value_present_o = head.present;
  assign last_of_token_o = head.last;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt <= 3'd4)
    else $error("result queue overflow");
  a_mid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_token_o |-> token_kind_o == KindNegate && value_present_o)
    else $error("inner item carries a kind or no byte");
  a_lock_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && lock && char_byte_i != 8'd0 |-> n == 2'd0)
    else $error("output while locked on error");
  a_two_max: assert property (@(posedge clk_i) disable iff (!rst_ni) n != 2'd3)
    else $error("too many items for one byte");

endmodule

// File: tb/source_token_lexer_checker.sv
// Checker for the source token lexer: watches both channels, predicts the token
// items of every accepted source byte and compares them in order.
// Depends on stl_pkg for the scan modes and kind codes.
`timescale 1ns / 100ps
module source_token_lexer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [5:0] token_kind_i,
  input  logic [7:0] value_byte_i,
  input  logic       value_present_i,
  input  logic       last_of_token_i,
  output int         fail_count_o,
  output int         pending_o
);
  import stl_pkg::*;

  mode_e      mode_q;
  logic [7:0] held_q;
  logic       held_v_q;
  logic [2:0] kw_q;
  logic [1:0] dots_q;
  logic       lock_q;
  item_t      token_q[$];

  assign pending_o = token_q.size();

  function automatic logic alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic xdigit(logic [7:0] c);
    return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  task automatic push_item(logic [5:0] k, logic [7:0] b, logic p, logic l);
    item_t it;
    it.kind = k;
    it.vbyte = p ? b : 8'd0;
    it.present = p;
    it.last = l;
    token_q.push_back(it);
  endtask

  task automatic shift_byte(logic [7:0] c);
    if (held_v_q) push_item(6'd0, held_q, 1'b1, 1'b0);
    held_q = c;
    held_v_q = 1'b1;
  endtask

  task automatic close_token(logic [5:0] k);
    if (held_v_q) push_item(k, held_q, 1'b1, 1'b1);
    else push_item(k, 8'd0, 1'b0, 1'b1);
    held_v_q = 1'b0;
    held_q = '0;
    kw_q = '0;
    dots_q = '0;
    mode_q = MODE_IDLE;
  endtask

  function automatic int one_kind(logic [7:0] c);
    case (c)
      ",": return 31;  ";": return 32;  ":": return 33;  "^": return 34;
      "%": return 35;  "!": return 0;   "#": return 36;  "?": return 37;
      "(": return 38;  "[": return 39;  "{": return 40;  ")": return 41;
      "]": return 42;  "}": return 43;  "/": return 45;  "@": return 46;
      default: return -1;
    endcase
  endfunction

  function automatic int two_kind(logic [7:0] a, logic [7:0] b);
    case (a)
      "-": return b == ">" ? 7 : b == "-" ? 8 : b == "?" ? 9 : -1;
      "+": return b == "+" ? 11 : -1;
      "=": return b == ">" ? 13 : b == "=" ? 14 : b == "?" ? 15 : -1;
      "&": return b == "&" ? 17 : b == "?" ? 18 : -1;
      "<": return b == "=" ? 20 : b == "-" ? 21 : b == "<" ? 22 : -1;
      "|": return b == "|" ? 24 : -1;
      ">": return b == "=" ? 26 : b == ">" ? 27 : -1;
      "*": return b == "*" ? 29 : -1;
      default: return -1;
    endcase
  endfunction

  function automatic logic [5:0] bare_kind(logic [7:0] a);
    case (a)
      "-": return 6'd10;  "+": return 6'd12;  "=": return 6'd16;
      "&": return 6'd19;  "<": return 6'd23;  "|": return 6'd25;
      ">": return 6'd28;
      default: return 6'd30;
    endcase
  endfunction

  task automatic begin_token(logic [7:0] c);
    int k;
    held_v_q = 1'b0;
    held_q = '0;
    if (c == 8'd0) begin
      close_token(KindEnd);
    end else if (c == 8'd13 || c == 8'd10 || c == " " || c == 8'd9) begin
    end else if (alpha(c)) begin
      mode_q = MODE_IDENT;
      kw_q = (c == "n") ? 3'd1 : KwMiss;
      shift_byte(c);
    end else if (digit(c)) begin
      mode_q = (c == "0") ? MODE_ZERO : MODE_DEC;
      shift_byte(c);
    end else if (c == "\"") begin
      mode_q = MODE_STR;
    end else if (c == "'") begin
      mode_q = MODE_CHR;
    end else if (c == ".") begin
      mode_q = MODE_DOTS;
      dots_q = 2'd1;
    end else if (c == "-" || c == "+" || c == "=" || c == "&" || c == "<" ||
                 c == "|" || c == ">" || c == "*") begin
      mode_q = MODE_OPER;
      shift_byte(c);
    end else begin
      k = one_kind(c);
      if (k >= 0) begin
        push_item(k[5:0], c, 1'b1, 1'b1);
      end else begin
        push_item(KindError, c, 1'b1, 1'b1);
        lock_q = 1'b1;
      end
    end
  endtask

  task automatic lex_byte(logic [7:0] c);
    int k;
    if (lock_q) begin
      if (c == 8'd0) begin
        lock_q = 1'b0;
        close_token(KindEnd);
      end
      return;
    end
    case (mode_q)
      MODE_IDENT: begin
        if (alpha(c) || digit(c)) begin
          if (kw_q == 3'd1 && c == "o") kw_q = 3'd2;
          else if (kw_q == 3'd2 && c == "t") kw_q = 3'd3;
          else kw_q = KwMiss;
          shift_byte(c);
        end else begin
          close_token(kw_q == 3'd3 ? KindNegate : KindId);
          begin_token(c);
        end
      end
      MODE_ZERO: begin
        if (c == "x" || c == "b") begin
          mode_q = (c == "x") ? MODE_HEX : MODE_BIN;
          held_v_q = 1'b0;
          held_q = '0;
        end else if (digit(c)) begin
          mode_q = MODE_DEC;
          shift_byte(c);
        end else begin
          close_token(KindInt);
          begin_token(c);
        end
      end
      MODE_DEC: if (digit(c)) shift_byte(c); else begin
        close_token(KindInt);
        begin_token(c);
      end
      MODE_HEX: if (xdigit(c)) shift_byte(c); else begin
        close_token(KindHex);
        begin_token(c);
      end
      MODE_BIN: if (c == "0" || c == "1") shift_byte(c); else begin
        close_token(KindBin);
        begin_token(c);
      end
      MODE_STR, MODE_CHR: begin
        logic [7:0] q;
        logic [5:0] kd;
        q = (mode_q == MODE_STR) ? "\"" : "'";
        kd = (mode_q == MODE_STR) ? KindString : KindChar;
        if (c == q) close_token(kd);
        else if (c == 8'd0) begin
          close_token(kd);
          begin_token(c);
        end else shift_byte(c);
      end
      MODE_OPER: begin
        k = two_kind(held_q, c);
        if (k >= 0) begin
          shift_byte(c);
          close_token(k[5:0]);
        end else begin
          close_token(bare_kind(held_q));
          begin_token(c);
        end
      end
      MODE_DOTS: begin
        if (dots_q < 2'd2) begin
          if (c == ".") dots_q = 2'd2;
          else begin
            held_q = ".";
            held_v_q = 1'b1;
            close_token(KindDot);
            begin_token(c);
          end
        end else if (c == ".") begin
          mode_q = MODE_BLOCK;
          dots_q = 2'd2;
        end else if (c == 8'd10) begin
          mode_q = MODE_IDLE;
          dots_q = '0;
        end else if (c == 8'd0) begin
          begin_token(c);
        end else begin
          mode_q = MODE_LINE;
          dots_q = '0;
        end
      end
      MODE_LINE: begin
        if (c == 8'd10) mode_q = MODE_IDLE;
        else if (c == 8'd0) begin_token(c);
      end
      MODE_BLOCK: begin
        if (c == 8'd0) begin_token(c);
        else if (c == ".") begin
          if (dots_q >= 2'd2) begin
            dots_q = '0;
            mode_q = MODE_IDLE;
          end else dots_q = dots_q + 2'd1;
        end else dots_q = '0;
      end
      default: begin
        mode_q = MODE_IDLE;
        begin_token(c);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t want;
    if (!rst_ni) begin
      mode_q = MODE_IDLE;
      held_q = '0;
      held_v_q = 1'b0;
      kw_q = '0;
      dots_q = '0;
      lock_q = 1'b0;
      token_q.delete();
      fail_count_o = 0;
    end else begin
      // results first: a byte's items appear only in a later cycle
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected item kind=%0d byte=%h present=%b last=%b",
                   $time, token_kind_i, value_byte_i, value_present_i,
                   last_of_token_i);
          fail_count_o++;
        end else begin
          want = token_q.pop_front();
          if (want.kind != token_kind_i || want.vbyte != value_byte_i ||
              want.present != value_present_i || want.last != last_of_token_i) begin
            $display("%0t: expected kind=%0d byte=%h present=%b last=%b, got kind=%0d byte=%h present=%b last=%b",
                     $time, want.kind, want.vbyte, want.present, want.last,
                     token_kind_i, value_byte_i, value_present_i, last_of_token_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) lex_byte(char_byte_i);
    end
  end

endmodule

// File: tb/source_token_lexer_core_test.sv
// Testbench top for source_token_lexer_core: feeds directed and random source
// text with bursty requests and a stalling receiver; checker gives the verdict count.
// Depends on stl_pkg, the lexer RTL and source_token_lexer_checker.
`timescale 1ns / 100ps
module source_token_lexer_core_test;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] token_kind;
  logic [7:0] value_byte;
  logic       value_present;
  logic       last_of_token;
  int         fail_count;
  int         pending;
  int         gap_left = 0;
  int         burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  source_token_lexer_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .char_byte_i(char_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .token_kind_o(token_kind), .value_byte_o(value_byte),
    .value_present_o(value_present), .last_of_token_o(last_of_token)
  );

  source_token_lexer_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .char_byte_i(char_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .token_kind_i(token_kind), .value_byte_i(value_byte),
    .value_present_i(value_present), .last_of_token_i(last_of_token),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: phases of free flow and of random stalls
  always @(negedge clk) begin
    int ph;
    ph = int'(($time / 400) % 3);
    if (ph == 0) out_ready <= 1'b1;
    else if (ph == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 1) != 0);
  end

  task automatic send_byte(logic [7:0] c);
    while (gap_left > 0) begin
      @(negedge clk);
      gap_left--;
    end
    in_valid <= 1'b1;
    char_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
    end
    if (gap_left > 0) in_valid <= 1'b0;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_byte(int cls);
    string ops;
    ops = "-+=&<|>*,;:^%!#?([{)]}/@.";
    case (cls)
      0: return 8'(8'd97 + $urandom_range(0, 25));
      1: return 8'(8'd65 + $urandom_range(0, 25));
      2: return 8'(8'd48 + $urandom_range(0, 9));
      3: return ops[$urandom_range(0, ops.len() - 1)];
      4: begin
        case ($urandom_range(0, 3))
          0: return " ";
          1: return 8'd10;
          2: return 8'd13;
          default: return 8'd9;
        endcase
      end
      5: return 8'($urandom_range(1, 255));
      default: return "\"";
    endcase
  endfunction

  initial begin
    int n;
    int sent;
    logic [7:0] c;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_text("not nota n1 Zz9 0 0x 0xfF 0b 0b102 0129 \"\" \"ab\xff\" '' 'q' ");
    send_byte(8'd0);
    send_text("-> -- -? - ++ + => == =? = && &? & <= <- << < || | >= >> > ** *");
    send_text(",;:^%!#?([{)]}/@. .x");
    send_byte(8'd0);
    send_text("a..cmt\nb...x..y...c... \"open");
    send_byte(8'd0);
    send_text("..nl");
    send_byte(8'd0);
    send_text("x $skip\x80 ok");
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd0);
    if (gap_left == 0) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
    sent = 0;
    while (sent < 24) begin
      n = $urandom_range(2, 9);
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < n; i++) send_byte(pick_byte(5));
      end else if ($urandom_range(0, 6) == 0) begin
        send_byte("\"");
        for (int i = 0; i < n; i++) send_byte(pick_byte($urandom_range(0, 5)));
        if ($urandom_range(0, 3) != 0) send_byte("\"");
      end else if ($urandom_range(0, 7) == 0) begin
        send_text("0");
        send_byte($urandom_range(0, 1) ? "x" : "b");
        for (int i = 0; i < n; i++) send_byte(pick_byte($urandom_range(0, 2)));
      end else begin
        for (int i = 0; i < n; i++) send_byte(pick_byte($urandom_range(0, 4)));
      end
      sent += n + 1;
      if ($urandom_range(0, 6) == 0) send_byte(8'd0);
    end
    send_byte(8'd0);
    if (gap_left == 0) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
